### src/aesf_pkg.sv
// Shared types and constants for the ANSI escape strip line framer.
package aesf_pkg;

	// Byte values the parser and framer look for.
	localparam logic [7:0] CHAR_ESC       = 8'h1B;
	localparam logic [7:0] CHAR_BEL       = 8'h07;
	localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
	localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
	localparam logic [7:0] CHAR_LBRACKET  = 8'h5B;
	localparam logic [7:0] CHAR_RBRACKET  = 8'h5D;
	localparam logic [7:0] CHAR_UPPER_P   = 8'h50;
	localparam logic [7:0] CHAR_UPPER_X   = 8'h58;
	localparam logic [7:0] CHAR_CARET     = 8'h5E;
	localparam logic [7:0] CHAR_UNDERLINE = 8'h5F;
	localparam logic [7:0] CSI_FINAL_LO   = 8'h40;
	localparam logic [7:0] CSI_FINAL_HI   = 8'h7E;
	localparam logic [7:0] PRINT_LO       = 8'd32;
	localparam logic [7:0] PRINT_HI       = 8'd126;

	// Column and line length width.
	localparam int COL_BITS = 13;

	// Configuration register indexes.
	localparam int CFG_INDEX_BITS = 1;
	localparam int CFG_DATA_BITS  = 13;
	localparam logic [CFG_INDEX_BITS-1:0] REG_ENABLE        = 1'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_LINE_CAPACITY = 1'd1;
	localparam logic [COL_BITS-1:0]       CAPACITY_RESET    = 13'd8191;

	// One result word, without its line number.
	typedef struct packed {
		logic [7:0]          char_out;
		logic                line_end;
		logic                forced_break;
		logic [COL_BITS-1:0] column;
		logic                last;
	} result_t;

endpackage

### src/aesf_parser.sv
// Escape sequence parser: tracks the sequence mode and flags bytes kept as text.
module aesf_parser (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       advance,
	input  logic [7:0] data_byte,
	output logic       keep
);

	typedef enum logic [3:0] {
		MODE_NORMAL = 4'd0,
		MODE_ESC    = 4'd1,
		MODE_CSI    = 4'd2,
		MODE_OSC    = 4'd3,
		MODE_DCS    = 4'd4,
		MODE_SOS    = 4'd5,
		MODE_PM     = 4'd6,
		MODE_APC    = 4'd7,
		MODE_STEND  = 4'd8
	} mode_t;

	mode_t mode_q;
	mode_t mode_next;

	// Next mode and keep decision for the byte at hand.
	always_comb begin
		mode_next = mode_q;
		keep      = 1'b0;
		case (mode_q)
			MODE_ESC: begin
				case (data_byte)
					aesf_pkg::CHAR_LBRACKET:  mode_next = MODE_CSI;
					aesf_pkg::CHAR_RBRACKET:  mode_next = MODE_OSC;
					aesf_pkg::CHAR_UPPER_P:   mode_next = MODE_DCS;
					aesf_pkg::CHAR_UPPER_X:   mode_next = MODE_SOS;
					aesf_pkg::CHAR_CARET:     mode_next = MODE_PM;
					aesf_pkg::CHAR_UNDERLINE: mode_next = MODE_APC;
					default:                  mode_next = MODE_NORMAL;
				endcase
			end
			MODE_CSI: begin
				if (data_byte inside {[aesf_pkg::CSI_FINAL_LO:aesf_pkg::CSI_FINAL_HI]}) begin
					mode_next = MODE_NORMAL;
				end
			end
			MODE_OSC: begin
				if (data_byte == aesf_pkg::CHAR_BEL) begin
					mode_next = MODE_NORMAL;
				end else if (data_byte == aesf_pkg::CHAR_ESC) begin
					mode_next = MODE_STEND;
				end
			end
			MODE_DCS, MODE_SOS, MODE_PM, MODE_APC: begin
				if (data_byte == aesf_pkg::CHAR_ESC) begin
					mode_next = MODE_STEND;
				end
			end
			MODE_STEND: begin
				// A bad terminator falls back to the OSC string state.
				mode_next = (data_byte == aesf_pkg::CHAR_BACKSLASH) ? MODE_NORMAL : MODE_OSC;
			end
			default: begin
				if (data_byte == aesf_pkg::CHAR_ESC) begin
					mode_next = MODE_ESC;
				end else begin
					mode_next = MODE_NORMAL;
					keep = (data_byte inside {[aesf_pkg::PRINT_LO:aesf_pkg::PRINT_HI]})
						|| (data_byte == aesf_pkg::CHAR_NEWLINE);
				end
			end
		endcase
	end

	// Mode register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
		end else if (advance) begin
			mode_q <= mode_next;
		end
	end

endmodule

### src/aesf_framer.sv
// Line framer: builds the one or two result words for a kept byte.
module aesf_framer #(
	parameter int LINE_NUMBER_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          commit,
	input  logic                          kept,
	input  logic [7:0]                    data_byte,
	input  logic [aesf_pkg::COL_BITS-1:0] line_capacity,
	output logic [1:0]                    count,
	output aesf_pkg::result_t             res_a,
	output logic [LINE_NUMBER_BITS-1:0]   ln_a,
	output aesf_pkg::result_t             res_b,
	output logic [LINE_NUMBER_BITS-1:0]   ln_b
);

	localparam logic [LINE_NUMBER_BITS-1:0] LN_MAX = '1;

	logic [aesf_pkg::COL_BITS-1:0] line_length_q;
	logic [LINE_NUMBER_BITS-1:0]   line_counter_q;
	logic [aesf_pkg::COL_BITS-1:0] cap_eff;
	logic [LINE_NUMBER_BITS-1:0]   counter_inc;
	logic                          is_newline;
	logic                          full;

	// Line full test and saturating counter step.
	always_comb begin
		cap_eff     = (line_capacity == '0) ? aesf_pkg::COL_BITS'(1) : line_capacity;
		full        = (line_length_q >= cap_eff);
		is_newline  = (data_byte == aesf_pkg::CHAR_NEWLINE);
		counter_inc = (line_counter_q == LN_MAX) ? line_counter_q
			: line_counter_q + LINE_NUMBER_BITS'(1);
	end

	// Result words: line end first when there is one, character after it.
	always_comb begin
		res_a              = '0;
		res_b              = '0;
		ln_a               = line_counter_q;
		ln_b               = counter_inc;
		res_b.char_out     = data_byte;
		res_b.column       = '0;
		res_b.last         = 1'b1;
		if (!kept) begin
			count = 2'd0;
		end else if (is_newline) begin
			count          = 2'd1;
			res_a.line_end = 1'b1;
			res_a.last     = 1'b1;
		end else if (full) begin
			count              = 2'd2;
			res_a.line_end     = 1'b1;
			res_a.forced_break = 1'b1;
		end else begin
			count          = 2'd1;
			res_a.char_out = data_byte;
			res_a.column   = line_length_q;
			res_a.last     = 1'b1;
		end
	end

	// Line length and line number registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_length_q  <= '0;
			line_counter_q <= '0;
		end else if (commit && kept) begin
			if (is_newline) begin
				line_length_q  <= '0;
				line_counter_q <= counter_inc;
			end else if (full) begin
				line_length_q  <= aesf_pkg::COL_BITS'(1);
				line_counter_q <= counter_inc;
			end else begin
				line_length_q  <= line_length_q + aesf_pkg::COL_BITS'(1);
			end
		end
	end

endmodule

### src/aesf_outq.sv
// Two-entry result queue that takes one or two words and hands out one a cycle while out_ready is high.
module aesf_outq #(
	parameter int LINE_NUMBER_BITS = 24
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push_valid,
	input  logic [1:0]                  push_count,
	input  aesf_pkg::result_t           res_a,
	input  logic [LINE_NUMBER_BITS-1:0] ln_a,
	input  aesf_pkg::result_t           res_b,
	input  logic [LINE_NUMBER_BITS-1:0] ln_b,
	output logic                        take,
	output logic                        out_valid,
	input  logic                        out_ready,
	output aesf_pkg::result_t           head,
	output logic [LINE_NUMBER_BITS-1:0] head_ln
);

	aesf_pkg::result_t           e0_q;
	aesf_pkg::result_t           e1_q;
	logic [LINE_NUMBER_BITS-1:0] ln0_q;
	logic [LINE_NUMBER_BITS-1:0] ln1_q;
	logic [1:0]                  cnt_q;
	logic                        pop;
	logic [1:0]                  cnt_p;
	logic [1:0]                  push_n;

	// Room check after this cycle's pop.
	always_comb begin
		pop       = (cnt_q != 2'd0) && out_ready;
		cnt_p     = cnt_q - {1'b0, pop};
		take      = push_valid && ({1'b0, cnt_p} + {1'b0, push_count} <= 3'd2);
		push_n    = take ? push_count : 2'd0;
		out_valid = (cnt_q != 2'd0);
		head      = e0_q;
		head_ln   = ln0_q;
	end

	// Queue count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_p + push_n;
		end
	end

	// Queue entries; the head shifts forward on a pop.
	always_ff @(posedge clk) begin
		case (cnt_p)
			2'd0: begin
				e0_q  <= res_a;
				ln0_q <= ln_a;
				e1_q  <= res_b;
				ln1_q <= ln_b;
			end
			2'd1: begin
				if (pop) begin
					e0_q  <= e1_q;
					ln0_q <= ln1_q;
				end
				e1_q  <= res_a;
				ln1_q <= ln_a;
			end
			default: begin
				e0_q  <= e0_q;
				ln0_q <= ln0_q;
			end
		endcase
	end

endmodule

### src/ansi_escape_strip_line_framer.sv
// ANSI escape strip line framer: one console byte a cycle in, one result word a cycle out, when neither side stalls.
// Accepts one raw byte per cycle into an input register; the parser and line framer turn
// it into zero, one or two result words (a line end, a character, or a forced line end
// followed by a character) which go into a two-entry output queue. With out_ready held
// high, bytes that yield at most one word flow at one byte per cycle; a byte that yields
// two words can hold back the input, since the output port delivers one word a cycle. Bytes
// are ignored while enable is 0. Configuration writes take effect at once and are meant to
// be made while no byte is in flight.
module ansi_escape_strip_line_framer #(
	parameter int LINE_NUMBER_BITS = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [aesf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [aesf_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [7:0]                          data_byte,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [7:0]                          char_out,
	output logic                                line_end,
	output logic                                forced_break,
	output logic [LINE_NUMBER_BITS-1:0]         line_number,
	output logic [aesf_pkg::COL_BITS-1:0]       column,
	output logic                                last
);

	logic                          enable_q;
	logic [aesf_pkg::COL_BITS-1:0] line_capacity_q;
	logic                          valid_s1;
	logic [7:0]                    data_s1;
	logic                          keep;
	logic                          take;
	logic                          advance;
	logic [1:0]                    count;
	aesf_pkg::result_t             res_a;
	aesf_pkg::result_t             res_b;
	aesf_pkg::result_t             head;
	logic [LINE_NUMBER_BITS-1:0]   ln_a;
	logic [LINE_NUMBER_BITS-1:0]   ln_b;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q        <= 1'b0;
			line_capacity_q <= aesf_pkg::CAPACITY_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				aesf_pkg::REG_ENABLE:        enable_q        <= cfg_data[0];
				aesf_pkg::REG_LINE_CAPACITY: line_capacity_q <= cfg_data;
				default:                     enable_q        <= enable_q;
			endcase
		end
	end

	// Input register; refills in the same cycle its word is taken.
	assign in_ready = !valid_s1 || take;
	assign advance  = take && enable_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= data_byte;
		end
	end

	aesf_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.data_byte (data_s1),
		.keep      (keep)
	);

	aesf_framer #(
		.LINE_NUMBER_BITS (LINE_NUMBER_BITS)
	) u_framer (
		.clk           (clk),
		.arst_n        (arst_n),
		.commit        (advance),
		.kept          (keep && enable_q),
		.data_byte     (data_s1),
		.line_capacity (line_capacity_q),
		.count         (count),
		.res_a         (res_a),
		.ln_a          (ln_a),
		.res_b         (res_b),
		.ln_b          (ln_b)
	);

	aesf_outq #(
		.LINE_NUMBER_BITS (LINE_NUMBER_BITS)
	) u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (valid_s1),
		.push_count (count),
		.res_a      (res_a),
		.ln_a       (ln_a),
		.res_b      (res_b),
		.ln_b       (ln_b),
		.take       (take),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.head       (head),
		.head_ln    (line_number)
	);

	// Output fields from the queue head.
	assign char_out     = head.char_out;
	assign line_end     = head.line_end;
	assign forced_break = head.forced_break;
	assign column       = head.column;
	assign last         = head.last;

endmodule

### tb/tb_top.sv
// Testbench for the ANSI escape strip line framer: directed and random console bytes checked word by word.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LNB = 24;

	// Parser states of the behavioral line framer.
	typedef enum logic [3:0] {
		PS_TEXT, PS_ESC, PS_CSI, PS_OSC, PS_DCS, PS_SOS, PS_PM, PS_APC, PS_ST_WAIT
	} parse_state_t;

	// Which side is idling at random.
	typedef enum logic [1:0] {IDLE_RX_HEAVY, IDLE_TX_HEAVY, IDLE_NONE} idle_mode_t;

	// One output word including its line number.
	typedef struct packed {
		aesf_pkg::result_t w;
		logic [LNB-1:0]    ln;
	} frame_word_t;

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                cfg_we = 1'b0;
	logic [aesf_pkg::CFG_INDEX_BITS-1:0] cfg_index = aesf_pkg::REG_ENABLE;
	logic [aesf_pkg::CFG_DATA_BITS-1:0]  cfg_data = '0;
	logic                                in_valid = 1'b0;
	logic                                in_ready;
	logic [7:0]                          data_byte = 8'h00;
	logic                                out_valid;
	logic                                out_ready = 1'b0;
	logic [7:0]                          char_out;
	logic                                line_end;
	logic                                forced_break;
	logic [LNB-1:0]                      line_number;
	logic [aesf_pkg::COL_BITS-1:0]       column;
	logic                                last;

	// Console bytes waiting to be sent and words waiting to be seen.
	logic [7:0]  byte_q[$];
	frame_word_t word_q[$];

	// Behavioral copy of the block's state and registers.
	logic                          log_on = 1'b0;
	logic [aesf_pkg::COL_BITS-1:0] cap_reg = aesf_pkg::CAPACITY_RESET;
	parse_state_t                  pstate = PS_TEXT;
	logic [aesf_pkg::COL_BITS-1:0] line_len = '0;
	logic [LNB-1:0]                line_cnt = '0;

	logic       byte_taken = 1'b0;
	int         fail_count = 0;
	idle_mode_t idle_mode = IDLE_RX_HEAVY;
	logic       hold_req = 1'b0;
	logic       hold_done = 1'b0;
	int         stall_left = 0;

	ansi_escape_strip_line_framer #(
		.LINE_NUMBER_BITS(LNB)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.char_out(char_out),
		.line_end(line_end),
		.forced_break(forced_break),
		.line_number(line_number),
		.column(column),
		.last(last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Queue one word of the expected output.
	task automatic expect_word(input logic [7:0] ch, input logic le, input logic fb,
			input logic [aesf_pkg::COL_BITS-1:0] col, input logic lst);
		frame_word_t w;
		w.w.char_out = ch;
		w.w.line_end = le;
		w.w.forced_break = fb;
		w.w.column = col;
		w.w.last = lst;
		w.ln = line_cnt;
		word_q.push_back(w);
	endtask

	// Close the current line and move on to the next one.
	task automatic close_line(input logic fb, input logic lst);
		expect_word(8'h00, 1'b1, fb, '0, lst);
		if (line_cnt != '1)
			line_cnt++;
		line_len = '0;
	endtask

	// Run one accepted byte through the parser and framer, queueing the words it yields.
	task automatic frame_byte(input logic [7:0] b);
		logic                          keep;
		logic [aesf_pkg::COL_BITS-1:0] cap;
		keep = 1'b0;
		if (!log_on)
			return;
		case (pstate)
		PS_ESC: begin
			case (b)
			aesf_pkg::CHAR_LBRACKET:  pstate = PS_CSI;
			aesf_pkg::CHAR_RBRACKET:  pstate = PS_OSC;
			aesf_pkg::CHAR_UPPER_P:   pstate = PS_DCS;
			aesf_pkg::CHAR_UPPER_X:   pstate = PS_SOS;
			aesf_pkg::CHAR_CARET:     pstate = PS_PM;
			aesf_pkg::CHAR_UNDERLINE: pstate = PS_APC;
			default:                  pstate = PS_TEXT;
			endcase
		end
		PS_CSI: begin
			if (b >= aesf_pkg::CSI_FINAL_LO && b <= aesf_pkg::CSI_FINAL_HI)
				pstate = PS_TEXT;
		end
		PS_OSC: begin
			if (b == aesf_pkg::CHAR_BEL)
				pstate = PS_TEXT;
			else if (b == aesf_pkg::CHAR_ESC)
				pstate = PS_ST_WAIT;
		end
		PS_DCS, PS_SOS, PS_PM, PS_APC: begin
			if (b == aesf_pkg::CHAR_ESC)
				pstate = PS_ST_WAIT;
		end
		// Anything but a backslash after ESC falls back to the OSC string state.
		PS_ST_WAIT: pstate = (b == aesf_pkg::CHAR_BACKSLASH) ? PS_TEXT : PS_OSC;
		default: begin
			pstate = PS_TEXT;
			if (b == aesf_pkg::CHAR_ESC)
				pstate = PS_ESC;
			else
				keep = (b >= aesf_pkg::PRINT_LO && b <= aesf_pkg::PRINT_HI)
					|| b == aesf_pkg::CHAR_NEWLINE;
		end
		endcase
		if (!keep)
			return;
		if (b == aesf_pkg::CHAR_NEWLINE) begin
			close_line(1'b0, 1'b1);
		end else begin
			// A zero capacity behaves as a capacity of one.
			cap = (cap_reg == '0) ? aesf_pkg::COL_BITS'(1) : cap_reg;
			if (line_len >= cap)
				close_line(1'b1, 1'b0);
			expect_word(b, 1'b0, 1'b0, line_len, 1'b1);
			line_len++;
		end
	endtask

	task automatic check_field(input string fname, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, want, got);
			fail_count++;
		end
	endtask

	// Check each word that leaves the block, predict from each byte taken in, then follow configuration writes.
	always @(posedge clk) begin : monitor
		frame_word_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (word_q.size() == 0) begin
					$display("%0t: unexpected word, expected none, got char %0h end %0b",
						$time, char_out, line_end);
					fail_count++;
				end else begin
					want = word_q.pop_front();
					check_field("char_out", want.w.char_out, char_out);
					check_field("line_end", want.w.line_end, line_end);
					check_field("forced_break", want.w.forced_break, forced_break);
					check_field("line_number", want.ln, line_number);
					check_field("column", want.w.column, column);
					check_field("last", want.w.last, last);
				end
			end
			byte_taken = in_valid && in_ready;
			if (byte_taken)
				frame_byte(data_byte);
			if (cfg_we) begin
				case (cfg_index)
				aesf_pkg::REG_ENABLE:        log_on = cfg_data[0];
				aesf_pkg::REG_LINE_CAPACITY: cap_reg = cfg_data;
				default: ;
				endcase
			end
		end
	end

	// Byte sender: offers the next queued byte unless it decides to idle.
	always @(negedge clk) begin : driver
		logic gap;
		if (arst_n && (!in_valid || byte_taken)) begin
			case (idle_mode)
			IDLE_RX_HEAVY: gap = ($urandom_range(99) < 8);
			IDLE_TX_HEAVY: gap = ($urandom_range(99) < 87);
			default:       gap = 1'b0;
			endcase
			if (byte_q.size() != 0 && !gap) begin
				in_valid <= 1'b1;
				data_byte <= byte_q.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Word receiver: random stalls, plus one long hold-off when asked for.
	always @(negedge clk) begin : receiver
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (hold_req && !hold_done) begin
			hold_done = 1'b1;
			stall_left = 300;
			out_ready <= 1'b0;
		end else begin
			case (idle_mode)
			IDLE_RX_HEAVY: out_ready <= ($urandom_range(99) >= 87);
			IDLE_TX_HEAVY: out_ready <= ($urandom_range(99) >= 8);
			default:       out_ready <= 1'b1;
			endcase
		end
	end

	task automatic write_reg(input logic [aesf_pkg::CFG_INDEX_BITS-1:0] idx,
			input logic [aesf_pkg::CFG_DATA_BITS-1:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Wait until every byte is sent and every word seen, then let the pipeline settle.
	// The check runs just after the falling edge, once the sender's updates have landed.
	task automatic drain();
		#1;
		while (byte_q.size() != 0 || in_valid || word_q.size() != 0) begin
			@(negedge clk);
			#1;
		end
		repeat (8) @(negedge clk);
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			byte_q.push_back(s[i]);
	endtask

	// String body: any byte except ESC and BEL.
	task automatic push_body();
		logic [7:0] b;
		repeat ($urandom_range(8)) begin
			do
				b = 8'($urandom_range(255));
			while (b == aesf_pkg::CHAR_ESC || b == aesf_pkg::CHAR_BEL);
			byte_q.push_back(b);
		end
	endtask

	// Mostly well-formed console traffic with random content, plus some raw noise.
	task automatic gen_traffic(input int n_bytes);
		int         base;
		int         kind;
		logic [7:0] b;
		base = byte_q.size();
		while (byte_q.size() - base < n_bytes) begin
			kind = $urandom_range(99);
			if (kind < 40) begin
				repeat ($urandom_range(12, 1))
					byte_q.push_back(8'($urandom_range(aesf_pkg::PRINT_HI,
						aesf_pkg::PRINT_LO)));
			end else if (kind < 50) begin
				byte_q.push_back(aesf_pkg::CHAR_NEWLINE);
			end else if (kind < 64) begin
				// Control sequence: parameter bytes, then a final byte.
				byte_q.push_back(aesf_pkg::CHAR_ESC);
				byte_q.push_back(aesf_pkg::CHAR_LBRACKET);
				repeat ($urandom_range(4))
					byte_q.push_back(8'($urandom_range(8'h3F, 8'h20)));
				byte_q.push_back(8'($urandom_range(aesf_pkg::CSI_FINAL_HI,
					aesf_pkg::CSI_FINAL_LO)));
			end else if (kind < 69) begin
				// Two-byte escape; these ranges hold no string introducer.
				byte_q.push_back(aesf_pkg::CHAR_ESC);
				if ($urandom_range(1))
					byte_q.push_back(8'($urandom_range(8'h4F, 8'h30)));
				else
					byte_q.push_back(8'($urandom_range(8'h7E, 8'h60)));
			end else if (kind < 78) begin
				// OSC ended by BEL or by ESC backslash.
				byte_q.push_back(aesf_pkg::CHAR_ESC);
				byte_q.push_back(aesf_pkg::CHAR_RBRACKET);
				push_body();
				if ($urandom_range(1)) begin
					byte_q.push_back(aesf_pkg::CHAR_BEL);
				end else begin
					byte_q.push_back(aesf_pkg::CHAR_ESC);
					byte_q.push_back(aesf_pkg::CHAR_BACKSLASH);
				end
			end else if (kind < 87) begin
				// DCS, SOS, PM or APC ended by ESC backslash.
				byte_q.push_back(aesf_pkg::CHAR_ESC);
				case ($urandom_range(3))
				0:       byte_q.push_back(aesf_pkg::CHAR_UPPER_P);
				1:       byte_q.push_back(aesf_pkg::CHAR_UPPER_X);
				2:       byte_q.push_back(aesf_pkg::CHAR_CARET);
				default: byte_q.push_back(aesf_pkg::CHAR_UNDERLINE);
				endcase
				push_body();
				byte_q.push_back(aesf_pkg::CHAR_ESC);
				byte_q.push_back(aesf_pkg::CHAR_BACKSLASH);
			end else if (kind < 91) begin
				// Bad terminator drops into the OSC state, which BEL then ends.
				byte_q.push_back(aesf_pkg::CHAR_ESC);
				byte_q.push_back(aesf_pkg::CHAR_UPPER_P);
				push_body();
				byte_q.push_back(aesf_pkg::CHAR_ESC);
				do
					b = 8'($urandom_range(aesf_pkg::PRINT_HI, aesf_pkg::PRINT_LO));
				while (b == aesf_pkg::CHAR_BACKSLASH);
				byte_q.push_back(b);
				push_body();
				byte_q.push_back(aesf_pkg::CHAR_BEL);
			end else begin
				repeat ($urandom_range(4, 1))
					byte_q.push_back(8'($urandom_range(255)));
			end
		end
	endtask

	// Stimulus: directed cases, then random phases over settings and idling.
	initial begin : stimulus
		logic [aesf_pkg::CFG_DATA_BITS-1:0] cap;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Disabled after reset: an ESC must not leave the parser inside a sequence.
		push_text("\033A\n");
		drain();
		write_reg(aesf_pkg::REG_ENABLE, aesf_pkg::CFG_DATA_BITS'(1));
		write_reg(aesf_pkg::REG_LINE_CAPACITY, aesf_pkg::CAPACITY_RESET);
		push_text("B\n");
		byte_q.push_back(8'h00);
		byte_q.push_back(8'hFF);
		byte_q.push_back(8'h1F);
		byte_q.push_back(8'h7F);
		push_text(" ~\n");
		push_text("\033c\033[@\033[~");
		push_text("\033]T\007\033]x\033\\");
		push_text("\033P\033\\\033X\033\\\033^\033\\\033_\033\\");
		push_text("\033P\033a\007Hi\n");
		drain();

		// Zero capacity acts as one, then a capacity lowered under the line length.
		write_reg(aesf_pkg::REG_LINE_CAPACITY, '0);
		push_text("abc\n");
		drain();
		write_reg(aesf_pkg::REG_LINE_CAPACITY, aesf_pkg::CFG_DATA_BITS'(10));
		push_text("abcdefgh");
		drain();
		write_reg(aesf_pkg::REG_LINE_CAPACITY, aesf_pkg::CFG_DATA_BITS'(3));
		push_text("Z\n");
		drain();

		// Random phases; the first one also holds the receiver off for a long stretch.
		for (int ph = 0; ph < 5; ph++) begin
			idle_mode = (ph < 2) ? IDLE_RX_HEAVY : (ph < 4) ? IDLE_TX_HEAVY : IDLE_NONE;
			case (ph)
			0:       cap = aesf_pkg::CFG_DATA_BITS'($urandom_range(40, 8));
			1:       cap = aesf_pkg::CFG_DATA_BITS'(1);
			2:       cap = aesf_pkg::CFG_DATA_BITS'($urandom_range(300, 2));
			3:       cap = aesf_pkg::CAPACITY_RESET;
			default: cap = aesf_pkg::CFG_DATA_BITS'($urandom_range(20, 1));
			endcase
			write_reg(aesf_pkg::REG_LINE_CAPACITY, cap);
			hold_req = (ph == 0);
			gen_traffic(360);
			drain();
			if (ph == 2) begin
				write_reg(aesf_pkg::REG_ENABLE, '0);
				gen_traffic(60);
				drain();
				write_reg(aesf_pkg::REG_ENABLE, aesf_pkg::CFG_DATA_BITS'(1));
			end
		end

		if (fail_count == 0 && word_q.size() == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

	initial begin : watchdog
		#10_000_000;
		$display("tb_top: done, errors");
		$finish;
	end

endmodule

### filelist.f
src/aesf_pkg.sv
src/aesf_parser.sv
src/aesf_framer.sv
src/aesf_outq.sv
src/ansi_escape_strip_line_framer.sv
tb/tb_top.sv
